// ===== src/plc_pkg.sv =====
`timescale 1ns / 1ps

package plc_pkg;

    // Index and count width for the largest supported list (256 cells plus a full count)
    localparam int INDEX_W = 9;
    localparam int DATA_W  = 32;

    typedef enum logic [2:0] {
        CMD_ADD_FRONT = 3'd0,
        CMD_ADD_BACK  = 3'd1,
        CMD_REM_FRONT = 3'd2,
        CMD_REM_BACK  = 3'd3,
        CMD_INSERT_AT = 3'd4,
        CMD_REMOVE_AT = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_IGNORED = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic [INDEX_W-1:0]         target;
        logic signed [DATA_W-1:0]   value;
    } t_shift_ctl;

endpackage

// ===== src/plc_cell.sv =====
`timescale 1ns / 1ps

module plc_cell #(
    parameter int IDX = 0
) (
    input  logic                                i_clk,
    input  plc_pkg::t_shift_ctl                 i_ctl,
    input  logic [plc_pkg::INDEX_W-1:0]         i_count,
    input  logic signed [plc_pkg::DATA_W-1:0]   i_left,
    input  logic signed [plc_pkg::DATA_W-1:0]   i_right,
    output logic signed [plc_pkg::DATA_W-1:0]   o_value,
    output logic signed [plc_pkg::DATA_W-1:0]   o_tail
);

    localparam int IW = plc_pkg::INDEX_W;
    localparam logic [IW-1:0] MY_IDX  = IW'(IDX);
    localparam logic [IW-1:0] MY_LAST = IW'(IDX + 1);

    logic signed [plc_pkg::DATA_W-1:0] r_value;
    logic signed [plc_pkg::DATA_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctl.op)
            plc_pkg::OP_INSERT: begin
                // open a gap at the target: cells above take their left neighbour
                if (MY_IDX > i_ctl.target) begin
                    n_value = i_left;
                end else if (MY_IDX == i_ctl.target) begin
                    n_value = i_ctl.value;
                end
            end
            plc_pkg::OP_REMOVE: begin
                // close the gap: target and above take their right neighbour
                if (MY_IDX >= i_ctl.target) begin
                    n_value = i_right;
                end
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_tail  = (i_count == MY_LAST) ? r_value : '0;

endmodule

// ===== src/plc_ctrl.sv =====
`timescale 1ns / 1ps

module plc_ctrl #(
    parameter int CAPACITY = 16
) (
    input  logic [2:0]                          i_command,
    input  logic signed [plc_pkg::DATA_W-1:0]   i_value,
    input  logic [4:0]                          i_position,
    input  logic [$clog2(CAPACITY+1)-1:0]       i_count,
    output plc_pkg::t_shift_ctl                 o_ctl,
    output plc_pkg::t_status                    o_status,
    output logic [$clog2(CAPACITY+1)-1:0]       o_next_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = ((CW > 5) ? CW : 5) + 1;
    localparam int IW = plc_pkg::INDEX_W;

    logic [EW-1:0] cnt_e;
    logic [EW-1:0] pos_e;
    logic          full;
    logic          empty;

    assign cnt_e = EW'(i_count);
    assign pos_e = EW'(i_position);
    assign full  = (cnt_e == EW'(CAPACITY));
    assign empty = (i_count == '0);

    always_comb begin
        o_ctl.op     = plc_pkg::OP_HOLD;
        o_ctl.target = '0;
        o_ctl.value  = i_value;
        o_status     = plc_pkg::ST_DONE;

        unique case (plc_pkg::t_cmd'(i_command))
            plc_pkg::CMD_ADD_FRONT: begin
                if (full) begin
                    o_status = plc_pkg::ST_FULL;
                end else begin
                    o_ctl.op = plc_pkg::OP_INSERT;
                end
            end
            plc_pkg::CMD_ADD_BACK: begin
                if (full) begin
                    o_status = plc_pkg::ST_FULL;
                end else begin
                    o_ctl.op     = plc_pkg::OP_INSERT;
                    o_ctl.target = IW'(i_count);
                end
            end
            plc_pkg::CMD_REM_FRONT: begin
                if (empty) begin
                    o_status = plc_pkg::ST_EMPTY;
                end else begin
                    o_ctl.op = plc_pkg::OP_REMOVE;
                end
            end
            plc_pkg::CMD_REM_BACK: begin
                if (empty) begin
                    o_status = plc_pkg::ST_EMPTY;
                end else begin
                    o_ctl.op     = plc_pkg::OP_REMOVE;
                    o_ctl.target = IW'(i_count - 1'b1);
                end
            end
            plc_pkg::CMD_INSERT_AT: begin
                // position test first, then the full test
                if (pos_e > cnt_e + EW'(1)) begin
                    o_status = plc_pkg::ST_IGNORED;
                end else if (full) begin
                    o_status = plc_pkg::ST_FULL;
                end else begin
                    o_ctl.op     = plc_pkg::OP_INSERT;
                    // one past the end appends
                    o_ctl.target = (pos_e > cnt_e) ? IW'(i_count) : IW'(pos_e);
                end
            end
            plc_pkg::CMD_REMOVE_AT: begin
                if (pos_e == '0) begin
                    if (empty) begin
                        o_status = plc_pkg::ST_EMPTY;
                    end else begin
                        o_ctl.op = plc_pkg::OP_REMOVE;
                    end
                end else if (pos_e >= cnt_e) begin
                    o_status = plc_pkg::ST_IGNORED;
                end else begin
                    o_ctl.op     = plc_pkg::OP_REMOVE;
                    o_ctl.target = IW'(pos_e);
                end
            end
            default: begin
                o_ctl.op = plc_pkg::OP_HOLD;
            end
        endcase
    end

    always_comb begin
        case (o_ctl.op)
            plc_pkg::OP_INSERT: o_next_count = i_count + 1'b1;
            plc_pkg::OP_REMOVE: o_next_count = i_count - 1'b1;
            default:            o_next_count = i_count;
        endcase
    end

endmodule

// ===== src/positional_ordered_list_unit.sv =====
`timescale 1ns / 1ps
// Result path: a taken word updates the cells, the count and r_status and sets r_pend;
// r_pend then loads the result ports and raises o_strobe, which is high for one cycle.
// Throughput: one word per cycle while busy is low; every cell of the chain shifts or loads together.
// busy is high while reset is held and in the first cycle after it is released.
// Reset (synchronous, active low) empties the list and drops any pending result.
module positional_ordered_list_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_command,
    input  logic signed [31:0]  i_value,
    input  logic [4:0]          i_position,
    output logic                o_strobe,
    output logic [1:0]          o_status,
    output logic [4:0]          o_length,
    output logic signed [31:0]  o_front_value,
    output logic signed [31:0]  o_back_value
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = plc_pkg::INDEX_W;
    localparam int DW = plc_pkg::DATA_W;

    logic                   accept;
    plc_pkg::t_shift_ctl    dec_ctl;
    plc_pkg::t_shift_ctl    cell_ctl;
    plc_pkg::t_status       dec_status;
    logic [CW-1:0]          dec_next_count;

    logic [CW-1:0]          r_count;
    logic [1:0]             r_status;
    logic                   r_pend;
    logic                   r_ready;
    logic                   r_strobe;
    logic [1:0]             r_out_status;
    logic [4:0]             r_out_length;
    logic signed [DW-1:0]   r_out_front;
    logic signed [DW-1:0]   r_out_back;

    logic signed [DW-1:0]   cell_value [CAPACITY];
    logic signed [DW-1:0]   cell_tail  [CAPACITY];
    logic signed [DW-1:0]   back_sel;

    assign busy   = ~r_ready;
    assign accept = start & r_ready;

    plc_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_command   (i_command),
        .i_value     (i_value),
        .i_position  (i_position),
        .i_count     (r_count),
        .o_ctl       (dec_ctl),
        .o_status    (dec_status),
        .o_next_count(dec_next_count)
    );

    always_comb begin
        cell_ctl = dec_ctl;
        if (!accept) begin
            cell_ctl.op = plc_pkg::OP_HOLD;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DW-1:0] left_in;
        logic signed [DW-1:0] right_in;

        if (g == 0) begin : g_first
            assign left_in = '0;
        end else begin : g_inner_l
            assign left_in = cell_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_in = '0;
        end else begin : g_inner_r
            assign right_in = cell_value[g+1];
        end

        plc_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (cell_ctl),
            .i_count(IW'(r_count)),
            .i_left (left_in),
            .i_right(right_in),
            .o_value(cell_value[g]),
            .o_tail (cell_tail[g])
        );
    end

    // only the last occupied cell drives its tail, so an OR picks it out
    always_comb begin
        back_sel = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            back_sel = back_sel | cell_tail[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready  <= 1'b0;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_ready  <= 1'b1;
            r_pend   <= accept;
            r_strobe <= r_pend;
            if (accept) begin
                r_count <= dec_next_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= dec_status;
        end
        if (r_pend) begin
            r_out_status <= r_status;
            r_out_length <= 5'(r_count);
            r_out_front  <= (r_count == '0) ? '0 : cell_value[0];
            r_out_back   <= back_sel;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_out_status;
    assign o_length      = r_out_length;
    assign o_front_value = r_out_front;
    assign o_back_value  = r_out_back;

endmodule

// ===== src/plc_checker.sv =====
`timescale 1ns / 1ps

module plc_checker #(
    parameter int CAPACITY = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_strobe,
    input logic [1:0]           o_status,
    input logic [4:0]           o_length,
    input logic signed [31:0]   o_front_value,
    input logic signed [31:0]   o_back_value
);

    // every accepted word must yield a strobe, registered through r_pend and then r_strobe
    a_accept_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_strobe)
        else $error("accepted word produced no result");

    a_empty_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_length == 5'd0) |-> (o_front_value == 32'sd0 && o_back_value == 32'sd0))
        else $error("empty list reported non-zero ends");

    a_full_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == plc_pkg::ST_FULL) |-> (o_length == 5'(CAPACITY)))
        else $error("full status with short list");

    a_empty_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == plc_pkg::ST_EMPTY) |-> (o_length == 5'd0))
        else $error("empty status with elements held");

endmodule

bind positional_ordered_list_unit plc_checker #(
    .CAPACITY(CAPACITY)
) u_plc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_status     (o_status),
    .o_length     (o_length),
    .o_front_value(o_front_value),
    .o_back_value (o_back_value)
);

// ===== dv/positional_ordered_list_unit_tb.sv =====
`timescale 1ns / 1ps

module positional_ordered_list_unit_tb;

    localparam int LIST_CAP = 16;

    // Command codes the block leaves unused
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] val;
        logic [4:0]         pos;
    } t_list_cmd;

    typedef struct packed {
        plc_pkg::t_status   status;
        logic [4:0]         length;
        logic signed [31:0] front;
        logic signed [31:0] back;
    } t_list_view;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         i_command = '0;
    logic signed [31:0] i_value = '0;
    logic [4:0]         i_position = '0;
    logic               o_strobe;
    logic [1:0]         o_status;
    logic [4:0]         o_length;
    logic signed [31:0] o_front_value;
    logic signed [31:0] o_back_value;

    t_list_cmd  cmd_backlog[$];
    t_list_view due_views[$];
    logic signed [31:0] shadow_cells [LIST_CAP];
    int         shadow_len = 0;
    int         send_idle_pct = 0;
    int         mismatches = 0;
    logic       word_taken = 1'b0;

    positional_ordered_list_unit #(.CAPACITY(LIST_CAP)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_length      (o_length),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Shadow list operations
    task automatic shadow_place(input int p, input logic signed [31:0] v);
        int i;
        for (i = shadow_len; i > p; i--)
            shadow_cells[i] = shadow_cells[i-1];
        shadow_cells[p] = v;
        shadow_len++;
    endtask

    task automatic shadow_take(input int p);
        int i;
        for (i = p; i + 1 < shadow_len; i++)
            shadow_cells[i] = shadow_cells[i+1];
        shadow_len--;
    endtask

    task automatic apply_list_cmd(input t_list_cmd c, output t_list_view v);
        plc_pkg::t_status st;
        int               p;
        st = plc_pkg::ST_DONE;
        p  = int'(c.pos);
        case (c.cmd)
            plc_pkg::CMD_ADD_FRONT: begin
                if (shadow_len >= LIST_CAP) st = plc_pkg::ST_FULL;
                else shadow_place(0, c.val);
            end
            plc_pkg::CMD_ADD_BACK: begin
                if (shadow_len >= LIST_CAP) st = plc_pkg::ST_FULL;
                else shadow_place(shadow_len, c.val);
            end
            plc_pkg::CMD_REM_FRONT: begin
                if (shadow_len == 0) st = plc_pkg::ST_EMPTY;
                else shadow_take(0);
            end
            plc_pkg::CMD_REM_BACK: begin
                if (shadow_len == 0) st = plc_pkg::ST_EMPTY;
                else shadow_take(shadow_len - 1);
            end
            plc_pkg::CMD_INSERT_AT: begin
                // position check wins over the full check
                if (p > shadow_len + 1) st = plc_pkg::ST_IGNORED;
                else if (shadow_len >= LIST_CAP) st = plc_pkg::ST_FULL;
                else shadow_place((p > shadow_len) ? shadow_len : p, c.val);
            end
            plc_pkg::CMD_REMOVE_AT: begin
                if (p == 0) begin
                    if (shadow_len == 0) st = plc_pkg::ST_EMPTY;
                    else shadow_take(0);
                end else if (p >= shadow_len) begin
                    st = plc_pkg::ST_IGNORED;
                end else begin
                    shadow_take(p);
                end
            end
            default: st = plc_pkg::ST_DONE;
        endcase
        v.status = st;
        v.length = shadow_len[4:0];
        v.front  = (shadow_len == 0) ? 32'sd0 : shadow_cells[0];
        v.back   = (shadow_len == 0) ? 32'sd0 : shadow_cells[shadow_len-1];
    endtask

    // Present the next word once the current one is taken or the port is idle
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || word_taken) begin
            if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                start      <= 1'b1;
                i_command  <= cmd_backlog[0].cmd;
                i_value    <= cmd_backlog[0].val;
                i_position <= cmd_backlog[0].pos;
                void'(cmd_backlog.pop_front());
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_list_view want;
        t_list_view next_view;
        word_taken <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (due_views.size() == 0) begin
                    $display("%0t: result with nothing expected: status %0d length %0d",
                             $time, o_status, o_length);
                    mismatches++;
                end else begin
                    want = due_views.pop_front();
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_status);
                        mismatches++;
                    end
                    if (o_length !== want.length) begin
                        $display("%0t: length expected %0d actual %0d",
                                 $time, want.length, o_length);
                        mismatches++;
                    end
                    if (o_front_value !== want.front) begin
                        $display("%0t: front expected %0d actual %0d",
                                 $time, want.front, o_front_value);
                        mismatches++;
                    end
                    if (o_back_value !== want.back) begin
                        $display("%0t: back expected %0d actual %0d",
                                 $time, want.back, o_back_value);
                        mismatches++;
                    end
                end
            end
            if (start && !busy) begin
                apply_list_cmd({i_command, i_value, i_position}, next_view);
                due_views.push_back(next_view);
            end
        end
    end

    task automatic push_cmd(input logic [2:0] c, input logic signed [31:0] v,
                            input logic [4:0] p);
        t_list_cmd w;
        w.cmd = c;
        w.val = v;
        w.pos = p;
        cmd_backlog.push_back(w);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [4:0] pick_position();
        if ($urandom_range(9) == 0)
            return 5'($urandom_range(31));
        return 5'($urandom_range(17));
    endfunction

    // Grow blocks lean on adds and inserts, shrink blocks on removals
    task automatic queue_block(input bit grow, input bit adds_only);
        int         n;
        logic [2:0] c;
        for (n = 0; n < 22; n++) begin
            if (adds_only || $urandom_range(99) < 85) begin
                case ($urandom_range(2))
                    0:       c = grow ? plc_pkg::CMD_ADD_FRONT : plc_pkg::CMD_REM_FRONT;
                    1:       c = grow ? plc_pkg::CMD_ADD_BACK  : plc_pkg::CMD_REM_BACK;
                    default: c = grow ? plc_pkg::CMD_INSERT_AT : plc_pkg::CMD_REMOVE_AT;
                endcase
            end else begin
                c = 3'($urandom_range(7));
            end
            push_cmd(c, pick_value(), pick_position());
        end
    endtask

    // Hold until the backlog is sent and every result is back, or the guard runs out
    task automatic drain();
        int guard;
        while (cmd_backlog.size() != 0 || start)
            @(posedge i_clk);
        guard = 0;
        while (due_views.size() != 0 && guard < 200) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(input int idle_pct);
        int b;
        send_idle_pct = idle_pct;
        queue_block(1'b1, 1'b1);
        for (b = 1; b < 6; b++)
            queue_block(b[0] == 1'b0, 1'b0);
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 30;
        push_cmd(plc_pkg::CMD_REM_FRONT, 32'sd5, 5'd31);
        push_cmd(plc_pkg::CMD_REM_BACK,  32'sd5, 5'd0);
        push_cmd(plc_pkg::CMD_REMOVE_AT, 32'sd0, 5'd0);
        push_cmd(plc_pkg::CMD_REMOVE_AT, 32'sd0, 5'd1);
        push_cmd(plc_pkg::CMD_INSERT_AT, 32'sd9, 5'd2);
        push_cmd(plc_pkg::CMD_INSERT_AT, 32'sh8000_0000, 5'd1);
        push_cmd(plc_pkg::CMD_ADD_FRONT, 32'sh7fff_ffff, 5'd17);
        push_cmd(plc_pkg::CMD_ADD_BACK,  32'sd0, 5'd16);
        push_cmd(plc_pkg::CMD_INSERT_AT, -32'sd1, 5'd1);
        push_cmd(CMD_SPARE_6,            32'sd1, 5'd3);
        push_cmd(CMD_SPARE_7,            -32'sd1, 5'd31);
        push_cmd(plc_pkg::CMD_INSERT_AT, 32'sh5555_aaaa, 5'd5);
        push_cmd(plc_pkg::CMD_INSERT_AT, 32'sh1234_5678, 5'd31);
        push_cmd(plc_pkg::CMD_REMOVE_AT, 32'sd0, 5'd3);
        push_cmd(plc_pkg::CMD_REMOVE_AT, 32'sd0, 5'd17);
        push_cmd(plc_pkg::CMD_REMOVE_AT, 32'sd0, 5'd1);
        push_cmd(plc_pkg::CMD_REM_FRONT, 32'sd0, 5'd0);
        push_cmd(plc_pkg::CMD_REM_BACK,  32'sd0, 5'd0);
        push_cmd(plc_pkg::CMD_REMOVE_AT, -32'sd1, 5'd0);
        push_cmd(plc_pkg::CMD_REM_BACK,  32'sd0, 5'd0);
        drain();

        run_phase(30);
        run_phase(64);
        run_phase(0);

        if (due_views.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, due_views.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
src/plc_pkg.sv
src/plc_cell.sv
src/plc_ctrl.sv
src/positional_ordered_list_unit.sv
src/plc_checker.sv
dv/positional_ordered_list_unit_tb.sv
